// ===== hdl/lrs_pkg.sv =====
// Lanczos resampler package: sizes, FSM state, command/status structs and
// the kernel weight table built at elaboration. No dependencies.
package lrs_pkg;

   localparam int ORDER       = 3;
   localparam int PHASE_BITS  = 6;
   localparam int SAMPLE_BITS = 16;
   localparam int MAX_OUTPUTS = 16;

   localparam int TAPS        = 2 * ORDER;
   localparam int PHASES      = 1 << PHASE_BITS;
   localparam int WEIGHT_BITS = 16;
   localparam int PROD_BITS   = SAMPLE_BITS + WEIGHT_BITS;
   localparam int ACC_BITS    = PROD_BITS + $clog2(TAPS);
   localparam int ROUND_SHIFT = 14;

   localparam int STEP_BITS   = 21;
   localparam int POS_BITS    = 32;
   localparam int FRAC_BITS   = 16;
   localparam int TRIAL_BITS  = 40;
   localparam int SKIP_BITS   = 17;
   localparam int SKIP_CNT_BITS = $clog2(SKIP_BITS);

   localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(65536);
   localparam logic signed [POS_BITS-1:0] POS_RESET = POS_BITS'((ORDER - 1) * 65536);
   localparam logic signed [POS_BITS-1:0] POS_LIMIT = POS_BITS'(-(ORDER - 1) * 65536);
   localparam logic signed [POS_BITS-1:0] POS_ONE = POS_BITS'(65536);

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic REG_POSITION_STEP = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL,
      ST_SUM,
      ST_SKIP,
      ST_SKIP_END
   } ctrl_state_type;

   typedef struct packed {
      logic                     load_item;
      logic                     mul;
      logic                     emit;
      logic                     emit_last;
      logic                     skip_try;
      logic [SKIP_CNT_BITS-1:0] skip_bit;
      logic                     add_step;
      logic                     finish;
   } dp_cmd_type;

   typedef struct packed {
      logic due;
      logic out_free;
   } dp_stat_type;

   typedef logic [TAPS-1:0][PHASES-1:0][WEIGHT_BITS-1:0] kernel_rom_type;

   localparam logic [63:0] PI_Q30  = 64'd3373259426;
   localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

   // restoring division, elaboration only
   function automatic logic [63:0] cdiv(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], n[i]};
         if (rem >= d) begin
            rem    = rem - d;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic [63:0] cmod(input logic [63:0] n, input logic [63:0] d);
      return n - cdiv(n, d) * d;
   endfunction

   function automatic logic [63:0] sin_fold_q30(input logic [63:0] r, input logic [63:0] den);
      logic [63:0] a;
      logic [63:0] a2;
      logic [63:0] term;
      logic [63:0] sum;
      a    = cdiv(r * PI_Q30, den);
      a2   = (a * a) >> 30;
      term = a;
      sum  = a;
      for (int k = 1; k <= 5; k++) begin
         term = cdiv((term * a2) >> 30, 64'((2 * k) * (2 * k + 1)));
         if (k % 2 == 1) begin
            sum = (sum >= term) ? sum - term : 64'd0;
         end else begin
            sum = sum + term;
         end
      end
      return sum;
   endfunction

   // bit 64 carries the sign, bits 63:0 the magnitude in Q30
   function automatic logic [64:0] sinc_q30(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] r;
      logic [63:0] s;
      logic [63:0] ang;
      logic        neg;
      r   = cmod(num, den << 1);
      neg = (r >= den);
      if (neg) begin
         r = r - den;
      end
      if ((r << 1) > den) begin
         r = den - r;
      end
      s   = sin_fold_q30(r, den);
      ang = cdiv(num * PI_Q30, den);
      if (ang == 64'd0) begin
         return {neg, ONE_Q30};
      end
      return {neg, cdiv(s << 30, ang)};
   endfunction

   function automatic logic [WEIGHT_BITS-1:0] kernel_q14(input int m);
      logic [63:0] um;
      logic [64:0] s1;
      logic [64:0] s2;
      logic [63:0] mag;
      um = (m < 0) ? 64'(-m) : 64'(m);
      if (um == 64'd0) begin
         return WEIGHT_BITS'(16384);
      end
      if (um >= 64'(ORDER * PHASES)) begin
         return '0;
      end
      s1  = sinc_q30(um, 64'(PHASES));
      s2  = sinc_q30(um, 64'(ORDER * PHASES));
      mag = (((s1[63:0] * s2[63:0]) >> 30) + (64'd1 << 15)) >> 16;
      if (mag > 64'd16384) begin
         mag = 64'd16384;
      end
      return (s1[64] != s2[64]) ? WEIGHT_BITS'(-mag) : WEIGHT_BITS'(mag);
   endfunction

   function automatic kernel_rom_type build_kernel_rom();
      kernel_rom_type rom;
      rom = '0;
      for (int k = 0; k < TAPS; k++) begin
         for (int p = 0; p < PHASES; p++) begin
            rom[k][p] = kernel_q14((ORDER - 1 - k) * PHASES + p);
         end
      end
      return rom;
   endfunction

   localparam kernel_rom_type KERNEL_ROM = build_kernel_rom();

endpackage

// ===== hdl/lrs_if.sv =====
// Lanczos resampler channel interfaces: request (samples) and response
// (resampled values). Depends on lrs_pkg.
interface lrs_req_if import lrs_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          stream_end;

   modport source (output valid, output sample, output stream_end, input ready);
   modport sink   (input valid, input sample, input stream_end, output ready);
endinterface

interface lrs_rsp_if import lrs_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] value;
   logic                          clipped;
   logic                          run_last;

   modport source (output valid, output value, output clipped, output run_last, input ready);
   modport sink   (input valid, input value, input clipped, input run_last, output ready);
endinterface

// ===== hdl/lrs_ctrl.sv =====
// Lanczos resampler controller: sequences item intake, output MACs and the
// position skip. Depends on lrs_pkg.
module lrs_ctrl import lrs_pkg::*; #(
   parameter int MAX_OUTPUTS_PER_INPUT = MAX_OUTPUTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   localparam int CNT_BITS = $clog2(MAX_OUTPUTS_PER_INPUT + 1);
   localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_OUTPUTS_PER_INPUT);

   ctrl_state_type           state_ff, state_in;
   logic [CNT_BITS-1:0]      count_ff, count_in;
   logic [SKIP_CNT_BITS-1:0] bit_ff, bit_in;
   logic                     more;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         bit_ff   <= bit_in;
      end
   end

   assign more = stat.due && (count_ff < CNT_MAX);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      bit_in    = bit_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               count_in      = '0;
               state_in      = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (more) begin
               state_in = ST_MUL;
            end else if (stat.due) begin
               bit_in   = SKIP_CNT_BITS'(SKIP_BITS - 1);
               state_in = ST_SKIP;
            end else begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            count_in = count_ff + 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = !more;
               state_in      = ST_CHECK;
            end
         end
         ST_SKIP: begin
            cmd.skip_try = 1'b1;
            cmd.skip_bit = bit_ff;
            if (bit_ff == '0) begin
               state_in = ST_SKIP_END;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         ST_SKIP_END: begin
            cmd.add_step = 1'b1;
            state_in     = ST_CHECK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/lrs_datapath.sv =====
// Lanczos resampler datapath: tap window, output position, parallel tap
// multipliers, adder with rounding and saturation, output register.
// Depends on lrs_pkg.
module lrs_datapath import lrs_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  dp_cmd_type                    cmd,
   output dp_stat_type                   stat,
   input  logic [STEP_BITS-1:0]          position_step,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic                          stream_end,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_value,
   output logic                          rsp_clipped,
   output logic                          rsp_run_last
);

   localparam int RND_BITS = ACC_BITS - ROUND_SHIFT;
   localparam logic signed [RND_BITS-1:0] SMAX =
      RND_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
   localparam logic signed [RND_BITS-1:0] SMIN = -SMAX - RND_BITS'(1);
   localparam logic signed [ACC_BITS-1:0] HALF = ACC_BITS'(1 << (ROUND_SHIFT - 1));

   logic signed [SAMPLE_BITS-1:0] window_ff [TAPS];
   logic signed [PROD_BITS-1:0]   prod_ff [TAPS];
   logic signed [POS_BITS-1:0]    pos_ff, pos_in;
   logic                          end_ff;
   logic                          valid_ff;
   logic signed [SAMPLE_BITS-1:0] value_ff;
   logic                          clipped_ff;
   logic                          last_ff;

   logic [STEP_BITS-1:0]          step_eff;
   logic [PHASE_BITS-1:0]         phase;
   logic signed [ACC_BITS-1:0]    acc;
   logic signed [RND_BITS-1:0]    rnd;
   logic signed [SAMPLE_BITS-1:0] sat_value;
   logic                          sat_clip;
   logic signed [TRIAL_BITS-1:0]  trial;

   assign step_eff = (position_step == '0) ? STEP_BITS'(1) : position_step;
   assign phase    = pos_ff[FRAC_BITS-1 -: PHASE_BITS];

   assign stat.due      = (pos_ff < POS_LIMIT);
   assign stat.out_free = !valid_ff || rsp_ready;

   always_comb begin
      acc = '0;
      for (int k = 0; k < TAPS; k++) begin
         acc = acc + ACC_BITS'(prod_ff[k]);
      end
      rnd = RND_BITS'((acc + HALF) >>> ROUND_SHIFT);
      if (rnd > SMAX) begin
         sat_value = SAMPLE_BITS'(SMAX);
         sat_clip  = 1'b1;
      end else if (rnd < SMIN) begin
         sat_value = SAMPLE_BITS'(SMIN);
         sat_clip  = 1'b1;
      end else begin
         sat_value = SAMPLE_BITS'(rnd);
         sat_clip  = 1'b0;
      end
   end

   assign trial = TRIAL_BITS'(pos_ff) +
                  $signed({1'b0, (TRIAL_BITS-1)'(step_eff) << cmd.skip_bit});

   always_comb begin
      pos_in = pos_ff;
      if (cmd.mul || cmd.add_step) begin
         pos_in = pos_ff + POS_BITS'(step_eff);
      end else if (cmd.skip_try) begin
         if (trial < TRIAL_BITS'(POS_LIMIT)) begin
            pos_in = POS_BITS'(trial);
         end
      end else if (cmd.finish) begin
         pos_in = end_ff ? POS_RESET : pos_ff - POS_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TAPS; k++) begin
            window_ff[k] <= '0;
         end
         pos_ff   <= POS_RESET;
         end_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         if (cmd.load_item) begin
            for (int k = 0; k < TAPS - 1; k++) begin
               window_ff[k] <= window_ff[k+1];
            end
            window_ff[TAPS-1] <= sample;
            end_ff            <= stream_end;
         end else if (cmd.finish && end_ff) begin
            for (int k = 0; k < TAPS; k++) begin
               window_ff[k] <= '0;
            end
            end_ff <= 1'b0;
         end
         if (cmd.emit) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         for (int k = 0; k < TAPS; k++) begin
            prod_ff[k] <= window_ff[k] * $signed(KERNEL_ROM[k][phase]);
         end
      end
      if (cmd.emit) begin
         value_ff   <= sat_value;
         clipped_ff <= sat_clip;
         last_ff    <= cmd.emit_last;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_value    = value_ff;
   assign rsp_clipped  = clipped_ff;
   assign rsp_run_last = last_ff;

endmodule

// ===== hdl/lanczos_resampler_1d.sv =====
// Lanczos resampler, order 3: each accepted item is checked for due positions,
// with a multiply and a sum step per result, plus a bitwise position skip when the
// per-item result limit leaves due positions; a finished result waits for the receiver.
// After an item is accepted, the first result passes the check state, the window MAC
// (one registered product per tap in parallel, then one sum) and the output register.
// Synchronous reset clears window and control, sets position to 2.0; step becomes 1.0.
// Depends on lrs_pkg, lrs_if, lrs_ctrl and lrs_datapath.
module lanczos_resampler_1d import lrs_pkg::*; #(
   parameter int MAX_OUTPUTS_PER_INPUT = MAX_OUTPUTS
) (
   input  logic                     clock,
   input  logic                     reset,
   lrs_req_if.sink                  req_chan,
   lrs_rsp_if.source                rsp_chan,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 step_sel;
   dp_cmd_type           cmd;
   dp_stat_type          stat;

   assign pready   = 1'b1;
   assign step_sel = (paddr[CSR_ADDR_BITS-1:2] == REG_POSITION_STEP);

   always_comb begin
      step_in = step_ff;
      if (psel && penable && pwrite && step_sel) begin
         step_in = pwdata[STEP_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
      end else begin
         step_ff <= step_in;
      end
   end

   assign prdata = step_sel ? CSR_DATA_BITS'(step_ff) : '0;

   lrs_ctrl #(
      .MAX_OUTPUTS_PER_INPUT (MAX_OUTPUTS_PER_INPUT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lrs_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .position_step (step_ff),
      .sample        (req_chan.sample),
      .stream_end    (req_chan.stream_end),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_value     (rsp_chan.value),
      .rsp_clipped   (rsp_chan.clipped),
      .rsp_run_last  (rsp_chan.run_last)
   );

   a_ready_drops: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("item accepted while previous item still in work");

   a_clip_at_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.clipped) |->
      (rsp_chan.value == {1'b0, {(SAMPLE_BITS-1){1'b1}}} ||
       rsp_chan.value == {1'b1, {(SAMPLE_BITS-1){1'b0}}}))
      else $error("clipped result not at a saturation rail");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (req_chan.ready && !rsp_chan.valid))
      else $error("block not idle after reset");

endmodule

// ===== sim/lanczos_resampler_1d_tb.sv =====
// Self-checking bench for lanczos_resampler_1d: drives sample items and step
// settings, predicts every resampled item with its own Lanczos table and MAC.
// Depends on lrs_pkg, lrs_if and the resampler RTL.
`timescale 1ns / 100ps

module lanczos_resampler_1d_tb;
   import lrs_pkg::*;

   localparam longint unsigned PI_FIX = 64'd3373259426;
   localparam longint POS_START = longint'(ORDER - 1) * 65536;
   localparam longint POS_FLOOR = -longint'(ORDER - 1) * 65536;
   localparam longint SMP_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint SMP_MIN = -SMP_MAX - 1;
   localparam logic [STEP_BITS-1:0] STEP_START = STEP_BITS'(65536);
   localparam int REG_SPARE = 1;
   localparam int SETTLE_CYCLES = 80;
   localparam int HOLD_CYCLES = 300;
   localparam int HOLD_AT_RESULT = 150;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic signed [SAMPLE_BITS-1:0] MAXV = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] MINV = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          stream_end;
   } sample_item_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] value;
      logic                          clipped;
      logic                          run_last;
   } resampled_type;

   logic clock;
   logic reset = 1'b1;

   logic                     psel    = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr   = '0;
   logic [CSR_DATA_BITS-1:0] pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   lrs_req_if req_bus ();
   lrs_rsp_if rsp_bus ();

   lanczos_resampler_1d dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   sample_item_type sample_feed[$];
   resampled_type   due_outputs[$];

   shortint                       weight_tab [TAPS][PHASES];
   logic signed [SAMPLE_BITS-1:0] history [TAPS];
   logic signed [POS_BITS-1:0]    position_acc;
   logic [STEP_BITS-1:0]          step_cfg;

   int errors = 0;
   int results_seen = 0;
   int idle_run = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   bit steady = 1'b0;
   bit req_taken = 1'b0;
   sample_item_type next_item;
   resampled_type   want;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // sin(pi*r/den) in Q30 by a truncated Taylor series, r <= den/2
   function automatic longint unsigned sine_q30(input longint unsigned r,
                                                input longint unsigned den);
      longint unsigned a, a2, term, acc;
      a    = (r * PI_FIX) / den;
      a2   = (a * a) >> 30;
      term = a;
      acc  = a;
      for (int n = 1; n <= 5; n++) begin
         term = ((term * a2) >> 30) / longint'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            acc = (acc >= term) ? acc - term : 64'd0;
         end else begin
            acc = acc + term;
         end
      end
      return acc;
   endfunction

   function automatic longint unsigned sinc_mag(input longint unsigned num,
                                                input longint unsigned den,
                                                output bit neg);
      longint unsigned r, s, ang;
      r   = num % (2 * den);
      neg = (r >= den);
      if (neg) begin
         r = r - den;
      end
      if (2 * r > den) begin
         r = den - r;
      end
      s   = sine_q30(r, den);
      ang = (num * PI_FIX) / den;
      if (ang == 0) begin
         return 64'd1 << 30;
      end
      return (s << 30) / ang;
   endfunction

   function automatic shortint lanczos_weight(input int m);
      longint unsigned um, s1, s2, mag;
      bit n1, n2;
      um = (m < 0) ? longint'(-m) : longint'(m);
      if (um == 0) begin
         return 16384;
      end
      if (um >= longint'(ORDER * PHASES)) begin
         return 0;
      end
      s1  = sinc_mag(um, PHASES, n1);
      s2  = sinc_mag(um, ORDER * PHASES, n2);
      mag = (((s1 * s2) >> 30) + (64'd1 << 15)) >> 16;
      if (mag > 16384) begin
         mag = 16384;
      end
      return (n1 != n2) ? -shortint'(mag) : shortint'(mag);
   endfunction

   task automatic clear_stream_state();
      for (int k = 0; k < TAPS; k++) begin
         history[k] = '0;
      end
      position_acc = POS_BITS'(POS_START);
   endtask

   // one accepted sample: shift the window, emit due positions up to the limit, skip the rest
   task automatic resample_step(input logic signed [SAMPLE_BITS-1:0] smp, input logic last);
      longint rel, stp, acc, v;
      int cnt, phase;
      resampled_type batch[$];
      resampled_type o;
      for (int k = 0; k < TAPS - 1; k++) begin
         history[k] = history[k + 1];
      end
      history[TAPS-1] = smp;
      stp = (step_cfg == 0) ? 1 : longint'(step_cfg);
      rel = longint'(position_acc);
      cnt = 0;
      while (rel < POS_FLOOR && cnt < MAX_OUTPUTS) begin
         phase = int'(rel[15:0]) >> (16 - PHASE_BITS);
         acc = 0;
         for (int k = 0; k < TAPS; k++) begin
            acc += longint'(history[k]) * longint'(weight_tab[k][phase]);
         end
         v = (acc + 8192) >>> 14;
         o.clipped = 1'b0;
         if (v > SMP_MAX) begin
            v = SMP_MAX;
            o.clipped = 1'b1;
         end
         if (v < SMP_MIN) begin
            v = SMP_MIN;
            o.clipped = 1'b1;
         end
         o.value    = v[SAMPLE_BITS-1:0];
         o.run_last = 1'b0;
         batch.push_back(o);
         cnt++;
         rel += stp;
      end
      if (rel < POS_FLOOR) begin
         rel += ((POS_FLOOR - rel + stp - 1) / stp) * stp;
      end
      if (cnt > 0) begin
         batch[cnt-1].run_last = 1'b1;
      end
      foreach (batch[i]) begin
         due_outputs.push_back(batch[i]);
      end
      position_acc = POS_BITS'(rel - 65536);
      if (last) begin
         clear_stream_state();
      end
   endtask

   task automatic report_mismatch(input string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   task automatic csr_write(input int idx, input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_BITS'(idx * 4);
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic check_step_reg();
      logic [CSR_DATA_BITS-1:0] got;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= CSR_ADDR_BITS'(int'(REG_POSITION_STEP) * 4);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      got = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== CSR_DATA_BITS'(step_cfg)) begin
         report_mismatch($sformatf("step readback %0h, want %0h", got, step_cfg));
      end
   endtask

   task automatic program_step(input logic [CSR_DATA_BITS-1:0] raw);
      csr_write(int'(REG_POSITION_STEP), raw);
      step_cfg = raw[STEP_BITS-1:0];
      check_step_reg();
   endtask

   task automatic add_item(input logic signed [SAMPLE_BITS-1:0] s, input logic last);
      sample_item_type it;
      it.sample     = s;
      it.stream_end = last;
      sample_feed.push_back(it);
   endtask

   task automatic wait_idle();
      while (sample_feed.size() != 0 || req_bus.valid || due_outputs.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(9))
         0: return MAXV;
         1: return MINV;
         2: return $urandom_range(1) ? MAXV : MINV;
         3, 4: return SAMPLE_BITS'(int'($urandom_range(511)) - 256);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   task automatic run_random_phase(input logic [CSR_DATA_BITS-1:0] raw_step, input int budget);
      int len, sent;
      program_step(raw_step);
      sent = 0;
      while (sent < budget) begin
         len = ($urandom_range(5) == 0) ? $urandom_range(1, 5) : $urandom_range(6, 30);
         if (len > budget - sent) begin
            len = budget - sent;
         end
         for (int i = 0; i < len; i++) begin
            add_item(pick_sample(), i == len - 1);
         end
         sent += len;
      end
      wait_idle();
   endtask

   // sample driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_bus.valid || req_taken) begin
            if (sample_feed.size() != 0 && (steady || $urandom_range(99) >= 15)) begin
               next_item = sample_feed.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.sample     <= next_item.sample;
               req_bus.stream_end <= next_item.stream_end;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result backpressure, with one long hold-off once traffic is flowing
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_bus.ready <= steady || $urandom_range(99) >= 15;
      end
   end

   // monitor, checker and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         req_taken = req_bus.valid && req_bus.ready;
         if (req_taken) begin
            resample_step(req_bus.sample, req_bus.stream_end);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (due_outputs.size() == 0) begin
               report_mismatch($sformatf("unexpected item, value %0d",
                                         $signed(rsp_bus.value)));
            end else begin
               want = due_outputs.pop_front();
               if (rsp_bus.value !== want.value) begin
                  report_mismatch($sformatf("item %0d value %0d, want %0d", results_seen,
                                            $signed(rsp_bus.value), $signed(want.value)));
               end
               if (rsp_bus.clipped !== want.clipped) begin
                  report_mismatch($sformatf("item %0d clipped %b, want %b", results_seen,
                                            rsp_bus.clipped, want.clipped));
               end
               if (rsp_bus.run_last !== want.run_last) begin
                  report_mismatch($sformatf("item %0d run_last %b, want %b", results_seen,
                                            rsp_bus.run_last, want.run_last));
               end
            end
         end
         if (req_taken || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_run = 0;
         end else begin
            idle_run++;
         end
         if (idle_run >= WATCHDOG_LIMIT) begin
            $display("lanczos_resampler_1d_tb: done, errors");
            $finish;
         end
      end
   end

   initial begin
      req_bus.valid      = 1'b0;
      req_bus.sample     = '0;
      req_bus.stream_end = 1'b0;
      rsp_bus.ready      = 1'b0;
      for (int k = 0; k < TAPS; k++) begin
         for (int p = 0; p < PHASES; p++) begin
            weight_tab[k][p] = lanczos_weight((ORDER - 1 - k) * PHASES + p);
         end
      end
      clear_stream_state();
      step_cfg = STEP_START;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      check_step_reg();

      // half step: window patterns that line up with the kernel signs and clip
      program_step(32'h0000_8000);
      add_item(MAXV, 1'b0);
      add_item(MINV, 1'b0);
      add_item(MAXV, 1'b0);
      add_item(MAXV, 1'b0);
      add_item(MINV, 1'b0);
      add_item(MAXV, 1'b0);
      add_item(MINV, 1'b0);
      add_item(MAXV, 1'b0);
      add_item(MINV, 1'b0);
      add_item(MINV, 1'b0);
      add_item(MAXV, 1'b0);
      add_item(MINV, 1'b1);
      // stream too short to finish a position, then a one-sample stream
      add_item('0, 1'b0);
      add_item('0, 1'b0);
      add_item(MAXV, 1'b1);
      add_item(MINV, 1'b1);
      wait_idle();

      // zero step runs as the smallest step: per-item limit and skipping
      program_step(32'h0000_0000);
      for (int i = 0; i < 8; i++) begin
         add_item(pick_sample(), i == 7);
      end
      wait_idle();

      // writes to an unused index leave the step alone
      csr_write(REG_SPARE, 32'hFFFF_FFFF);
      check_step_reg();

      steady = 1'b1;
      run_random_phase(32'h0001_0000, 23);
      steady = 1'b0;
      run_random_phase(32'h0000_1000, 23);
      run_random_phase(32'(int'($urandom_range(4096, 1048576))), 23);
      run_random_phase(32'h0010_0000, 23);
      run_random_phase(32'hFFFF_FFFF, 22);
      run_random_phase(32'(int'($urandom_range(1, 4095))), 22);

      if (errors == 0) begin
         $display("lanczos_resampler_1d_tb: done, clean");
      end else begin
         $display("lanczos_resampler_1d_tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/lrs_pkg.sv
hdl/lrs_if.sv
hdl/lrs_ctrl.sv
hdl/lrs_datapath.sv
hdl/lanczos_resampler_1d.sv
sim/lanczos_resampler_1d_tb.sv
